FILE: src/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg
// Shared widths, command codes, status codes and controller states for the
// indexed array store.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 9;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_DEL_RANGE = 3'd2,
        CMD_DEL_LAST  = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_REPLACE   = 3'd5,
        CMD_READ      = 3'd6,
        CMD_FIND      = 3'd7
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_FILL,
        S_SHIFT_DN,
        S_READ,
        S_FIND,
        S_HOLD
    } t_state;

endpackage

FILE: src/ias_ram.sv
// ----------------------------------------------------------------------------
// ias_ram
// Simple dual-port word memory: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ias_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic signed [DW-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic signed [DW-1:0] o_rd_data
);

    logic signed [DW-1:0] r_mem [DEPTH];
    logic signed [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/indexed_array_store.sv
// ----------------------------------------------------------------------------
// indexed_array_store
// Bounded ordered store of signed 32-bit words with a fill count: append,
// insert, delete range, delete last, clear, replace, read and find.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -----------------------------
//  command   in         i_in_valid / o_in_ready   i_cmd i_value i_location
//                                                 i_count
//  result    out        o_out_valid / i_out_ready o_status o_read_value o_found
//                                                 o_found_index o_fill_count
//
//  One command beat in flight at a time; every command gives one result beat.
//  Append writes the copies; insert moves the tail up from the end, then
//  writes the copies; delete range moves the tail down; find scans from loc
//  until a match or the last word; read goes through the registered read.
//  Delete last, clear, replace and errors need no walk.
//  The single memory port pair (one read, one write per cycle) sets the walk.
//  Reset (sync, active low) empties the store; memory contents are not cleared.
//  A finished result waits in a pending register while the output beat stalls;
//  the next command is taken once that result has moved to the output register.
//
module indexed_array_store #(
    parameter int CAPACITY = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ias_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [ias_pkg::DATA_W-1:0]   i_value,
    input  logic [ias_pkg::POS_W-1:0]           i_location,
    input  logic [ias_pkg::POS_W-1:0]           i_count,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ias_pkg::STAT_W-1:0]          o_status,
    output logic signed [ias_pkg::DATA_W-1:0]   o_read_value,
    output logic                                o_found,
    output logic [ias_pkg::FIDX_W-1:0]          o_found_index,
    output logic [ias_pkg::POS_W-1:0]           o_fill_count
);

    import ias_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);      // fill / pointer width
    localparam int AW = $clog2(CAPACITY);          // memory address width
    localparam int XW = ((FW > POS_W) ? FW : POS_W) + 2;  // check arithmetic
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    // control state
    t_state              r_state, n_state;
    logic [FW-1:0]       r_fill, n_fill;
    logic                r_pv, n_pv;           // walk read issued last cycle
    logic                r_o_valid, n_o_valid;

    // walk and payload registers
    logic [FW-1:0]       r_ptr, n_ptr;
    logic [FW-1:0]       r_wa, n_wa;           // address tied to the data in flight
    logic [FW-1:0]       r_cnt, n_cnt;
    logic [FW-1:0]       r_loc, n_loc;
    logic [FW-1:0]       r_end, n_end;
    logic signed [DATA_W-1:0] r_val, n_val;

    // pending result
    logic [STAT_W-1:0]        r_p_status, n_p_status;
    logic signed [DATA_W-1:0] r_p_rdval, n_p_rdval;
    logic                     r_p_found, n_p_found;
    logic [FIDX_W-1:0]        r_p_fidx, n_p_fidx;

    // output register
    logic [STAT_W-1:0]        r_o_status, n_o_status;
    logic signed [DATA_W-1:0] r_o_rdval, n_o_rdval;
    logic                     r_o_found, n_o_found;
    logic [FIDX_W-1:0]        r_o_fidx, n_o_fidx;
    logic [POS_W-1:0]         r_o_fill, n_o_fill;

    // memory ports
    logic                     wr_en, rd_en;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic signed [DATA_W-1:0] wr_data, rd_data;

    // widened views for checks and port truncation
    logic [XW-1:0] loc_x, cnt_x, fill_x, wa_x, end_sum_x;
    logic [FW-1:0] ptr_dec, up_target, dn_target, fill_last;

    assign loc_x     = XW'(i_location);
    assign cnt_x     = XW'(i_count);
    assign fill_x    = XW'(r_fill);
    assign wa_x      = XW'(r_wa);
    assign end_sum_x = loc_x + cnt_x;
    assign ptr_dec   = r_ptr - FW'(1);
    assign up_target = ptr_dec + r_cnt;
    assign dn_target = r_ptr - r_cnt;
    assign fill_last = r_fill - FW'(1);

    ias_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_pv       = r_pv;
        n_ptr      = r_ptr;
        n_wa       = r_wa;
        n_cnt      = r_cnt;
        n_loc      = r_loc;
        n_end      = r_end;
        n_val      = r_val;
        n_p_status = r_p_status;
        n_p_rdval  = r_p_rdval;
        n_p_found  = r_p_found;
        n_p_fidx   = r_p_fidx;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_status = r_o_status;
        n_o_rdval  = r_o_rdval;
        n_o_found  = r_o_found;
        n_o_fidx   = r_o_fidx;
        n_o_fill   = r_o_fill;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_val;
        rd_en      = 1'b0;
        rd_addr    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val      = i_value;
                    n_p_status = ST_OK;
                    n_p_rdval  = '0;
                    n_p_found  = 1'b0;
                    n_p_fidx   = '0;
                    n_pv       = 1'b0;
                    n_state    = S_HOLD;
                    case (t_cmd'(i_cmd))
                        CMD_APPEND: begin
                            if (fill_x + cnt_x > CAP_X) begin
                                n_p_status = ST_FULL;
                            end else if (i_count != '0) begin
                                n_fill  = FW'(fill_x + cnt_x);
                                n_ptr   = r_fill;
                                n_cnt   = FW'(cnt_x);
                                n_state = S_FILL;
                            end
                        end
                        CMD_INSERT: begin
                            if (loc_x > fill_x) begin
                                n_p_status = ST_RANGE;
                            end else if (fill_x + cnt_x > CAP_X) begin
                                n_p_status = ST_FULL;
                            end else if (i_count != '0) begin
                                // move the tail up first, then write the copies
                                n_fill  = FW'(fill_x + cnt_x);
                                n_ptr   = r_fill;
                                n_loc   = FW'(loc_x);
                                n_cnt   = FW'(cnt_x);
                                n_state = S_SHIFT_UP;
                            end
                        end
                        CMD_DEL_RANGE: begin
                            if (loc_x >= fill_x || end_sum_x > fill_x) begin
                                n_p_status = ST_RANGE;
                            end else if (i_count != '0) begin
                                n_fill  = FW'(fill_x - cnt_x);
                                n_ptr   = FW'(end_sum_x);
                                n_cnt   = FW'(cnt_x);
                                n_end   = r_fill;
                                n_state = S_SHIFT_DN;
                            end
                        end
                        CMD_DEL_LAST: begin
                            if (r_fill == '0) begin
                                n_p_status = ST_RANGE;
                            end else begin
                                n_fill = fill_last;
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill = '0;
                        end
                        CMD_REPLACE: begin
                            if (loc_x >= fill_x) begin
                                n_p_status = ST_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(loc_x);
                                wr_data = i_value;
                            end
                        end
                        CMD_READ: begin
                            if (loc_x >= fill_x) begin
                                n_p_status = ST_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(loc_x);
                                n_state = S_READ;
                            end
                        end
                        CMD_FIND: begin
                            if (loc_x >= fill_x) begin
                                n_p_status = ST_RANGE;
                            end else begin
                                n_ptr   = FW'(loc_x);
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                            n_state = S_HOLD;
                        end
                    endcase
                end
            end

            S_SHIFT_UP: begin
                // read word i-1 this cycle, write it to i-1+count the next
                wr_en   = r_pv;
                wr_addr = r_wa[AW-1:0];
                wr_data = rd_data;
                if (r_ptr != r_loc) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_dec[AW-1:0];
                    n_ptr   = ptr_dec;
                    n_wa    = up_target;
                    n_pv    = 1'b1;
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_FILL;
                end
            end

            S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr[AW-1:0];
                wr_data = r_val;
                n_ptr   = r_ptr + FW'(1);
                n_cnt   = r_cnt - FW'(1);
                if (r_cnt == FW'(1)) begin
                    n_state = S_HOLD;
                end
            end

            S_SHIFT_DN: begin
                // read word i+count this cycle, write it to i the next
                wr_en   = r_pv;
                wr_addr = r_wa[AW-1:0];
                wr_data = rd_data;
                if (r_ptr != r_end) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr[AW-1:0];
                    n_ptr   = r_ptr + FW'(1);
                    n_wa    = dn_target;
                    n_pv    = 1'b1;
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_HOLD;
                end
            end

            S_READ: begin
                n_p_rdval = rd_data;
                n_state   = S_HOLD;
            end

            S_FIND: begin
                if (r_pv && rd_data == r_val) begin
                    n_p_found = 1'b1;
                    n_p_fidx  = wa_x[FIDX_W-1:0];
                    n_pv      = 1'b0;
                    n_state   = S_HOLD;
                end else if (r_pv && r_wa == fill_last) begin
                    n_pv    = 1'b0;
                    n_state = S_HOLD;
                end else if (r_ptr != r_fill) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr[AW-1:0];
                    n_wa    = r_ptr;
                    n_ptr   = r_ptr + FW'(1);
                    n_pv    = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
            end

            S_HOLD: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_p_status;
                    n_o_rdval  = r_p_rdval;
                    n_o_found  = r_p_found;
                    n_o_fidx   = r_p_fidx;
                    n_o_fill   = fill_x[POS_W-1:0];
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_pv      <= n_pv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_wa       <= n_wa;
        r_cnt      <= n_cnt;
        r_loc      <= n_loc;
        r_end      <= n_end;
        r_val      <= n_val;
        r_p_status <= n_p_status;
        r_p_rdval  <= n_p_rdval;
        r_p_found  <= n_p_found;
        r_p_fidx   <= n_p_fidx;
        r_o_status <= n_o_status;
        r_o_rdval  <= n_o_rdval;
        r_o_found  <= n_o_found;
        r_o_fidx   <= n_o_fidx;
        r_o_fill   <= n_o_fill;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_rdval;
    assign o_found       = r_o_found;
    assign o_found_index = r_o_fidx;
    assign o_fill_count  = r_o_fill;

endmodule

FILE: tb/ias_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ias_checker
// Watches the command and result channels of the indexed array store, keeps
// its own copy of the held words, and checks every result beat field by field.
// ----------------------------------------------------------------------------
module ias_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [ias_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [ias_pkg::DATA_W-1:0]   i_value,
    input  logic [ias_pkg::POS_W-1:0]           i_location,
    input  logic [ias_pkg::POS_W-1:0]           i_count,

    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [ias_pkg::STAT_W-1:0]          i_status,
    input  logic signed [ias_pkg::DATA_W-1:0]   i_read_value,
    input  logic                                i_found,
    input  logic [ias_pkg::FIDX_W-1:0]          i_found_index,
    input  logic [ias_pkg::POS_W-1:0]           i_fill_count,

    output int                                  o_mismatch_count,
    output int                                  o_pending
);

    import ias_pkg::*;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [FIDX_W-1:0]        found_index;
        logic [POS_W-1:0]         fill_count;
    } t_result;

    // held words, index 0 first; size is the fill level
    logic signed [DATA_W-1:0] held_words[$];
    t_result                  expected_results[$];
    int                       mismatches = 0;

    function automatic t_result apply_command(t_cmd cmd, logic signed [DATA_W-1:0] value,
                                              int loc, int cnt);
        t_result r;
        int      fill;
        r.status      = ST_OK;
        r.read_value  = '0;
        r.found       = 1'b0;
        r.found_index = '0;
        fill          = held_words.size();
        case (cmd)
            CMD_APPEND: begin
                if (fill + cnt > CAPACITY) r.status = ST_FULL;
                else repeat (cnt) held_words.push_back(value);
            end
            CMD_INSERT: begin
                // position check ranks ahead of the full check
                if (loc > fill) r.status = ST_RANGE;
                else if (fill + cnt > CAPACITY) r.status = ST_FULL;
                else repeat (cnt) held_words.insert(loc, value);
            end
            CMD_DEL_RANGE: begin
                if (loc >= fill || loc + cnt > fill) r.status = ST_RANGE;
                else repeat (cnt) held_words.delete(loc);
            end
            CMD_DEL_LAST: begin
                if (fill == 0) r.status = ST_RANGE;
                else void'(held_words.pop_back());
            end
            CMD_CLEAR: held_words.delete();
            CMD_REPLACE: begin
                if (loc >= fill) r.status = ST_RANGE;
                else held_words[loc] = value;
            end
            CMD_READ: begin
                if (loc >= fill) r.status = ST_RANGE;
                else r.read_value = held_words[loc];
            end
            CMD_FIND: begin
                if (loc >= fill) r.status = ST_RANGE;
                else begin
                    for (int i = loc; i < fill; i++) begin
                        if (held_words[i] == value) begin
                            r.found       = 1'b1;
                            r.found_index = i[FIDX_W-1:0];
                            break;
                        end
                    end
                end
            end
            default: r.status = ST_OK;
        endcase
        r.fill_count = POS_W'(held_words.size());
        return r;
    endfunction

    task automatic compare_result(t_result got);
        t_result want;
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            mismatches++;
        end
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
        end
        if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
            mismatches++;
        end
        if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            held_words.delete();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_command(t_cmd'(i_cmd), i_value,
                                                         int'(i_location), int'(i_count)));
            if (i_out_valid && i_out_ready) begin
                got.status      = i_status;
                got.read_value  = i_read_value;
                got.found       = i_found;
                got.found_index = i_found_index;
                got.fill_count  = i_fill_count;
                if (expected_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end else begin
                    compare_result(got);
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_pending        <= expected_results.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives command beats into the indexed array store: a directed opening run,
// then random command mixes under three idle/stall profiles. A checker
// instance predicts and compares every result beat; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ias_pkg::*;

    localparam int CAPACITY      = 256;
    localparam int RANDOM_BEATS  = 550;
    localparam int DRAIN_CYCLES  = 300;    // longer than the worst walk of one command
    localparam int WATCHDOG_MAX  = 20000;  // cycles without any beat on either channel

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [CMD_W-1:0]         i_cmd        = '0;
    logic signed [DATA_W-1:0] i_value      = '0;
    logic [POS_W-1:0]         i_location   = '0;
    logic [POS_W-1:0]         i_count      = '0;
    logic                     i_out_ready  = 1'b0;

    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [STAT_W-1:0]        o_status;
    logic signed [DATA_W-1:0] o_read_value;
    logic                     o_found;
    logic [FIDX_W-1:0]        o_found_index;
    logic [POS_W-1:0]         o_fill_count;

    int mismatch_count;
    int pending;

    // idle profile, changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // last fill level seen on the result channel; steers locations and counts
    int seen_fill = 0;
    int quiet_cycles = 0;

    // small value pool so finds hit and repeated words are common
    logic signed [DATA_W-1:0] value_pool[6];

    indexed_array_store #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_location    (i_location),
        .i_count       (i_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_fill_count  (o_fill_count)
    );

    ias_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_value          (i_value),
        .i_location       (i_location),
        .i_count          (i_count),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_read_value     (o_read_value),
        .i_found          (o_found),
        .i_found_index    (o_found_index),
        .i_fill_count     (o_fill_count),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: random stall per cycle at the current profile
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) seen_fill <= int'(o_fill_count);
    end

    // watchdog: any beat on either channel restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One command beat. Idle gaps come first with valid low; once raised,
    // valid and payload hold until the beat is taken. The next call lands its
    // single update in the same step as the acceptance edge, so back-to-back
    // beats keep valid high.
    task automatic send_command(t_cmd cmd, logic signed [DATA_W-1:0] value, int loc, int cnt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        i_location <= loc[POS_W-1:0];
        i_count    <= cnt[POS_W-1:0];
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready)) @(posedge i_clk);
    endtask

    // Random command shaped around the last seen fill level: mostly sane
    // locations and small counts, some out-of-range noise, rare full-size runs.
    task automatic send_random_command();
        t_cmd                     cmd;
        int                       pick;
        int                       fill;
        int                       loc;
        int                       cnt;
        logic signed [DATA_W-1:0] value;
        fill = seen_fill;
        pick = $urandom_range(0, 99);
        if      (pick < 18) cmd = CMD_APPEND;
        else if (pick < 36) cmd = CMD_INSERT;
        else if (pick < 50) cmd = CMD_DEL_RANGE;
        else if (pick < 58) cmd = CMD_DEL_LAST;
        else if (pick < 61) cmd = CMD_CLEAR;
        else if (pick < 71) cmd = CMD_REPLACE;
        else if (pick < 85) cmd = CMD_READ;
        else                cmd = CMD_FIND;
        // pull back when the store runs near capacity
        if (fill > 160 && $urandom_range(0, 1) == 1)
            cmd = ($urandom_range(0, 1) == 1) ? CMD_DEL_RANGE : CMD_DEL_LAST;

        if ($urandom_range(0, 9) < 6) value = value_pool[$urandom_range(0, 5)];
        else                          value = $urandom;

        if ($urandom_range(0, 9) < 8) loc = $urandom_range(0, fill);
        else                          loc = $urandom_range(0, 511);

        pick = $urandom_range(0, 49);
        case (cmd)
            CMD_APPEND, CMD_INSERT: begin
                if      (pick < 40) cnt = $urandom_range(0, 6);
                else if (pick < 48) cnt = $urandom_range(0, 40);
                else if (pick < 49) cnt = CAPACITY;
                else                cnt = $urandom_range(0, 511);
            end
            CMD_DEL_RANGE: begin
                if (pick < 30)                   cnt = $urandom_range(0, 4);
                else if (pick < 48 && fill > loc) cnt = $urandom_range(0, fill - loc);
                else                             cnt = $urandom_range(0, 511);
            end
            default: cnt = $urandom_range(0, 511);  // field unused
        endcase
        send_command(cmd, value, loc, cnt);
    endtask

    initial begin
        value_pool[0] = 32'sd0;
        value_pool[1] = -32'sd1;
        value_pool[2] = 32'sh7fff_ffff;
        value_pool[3] = 32'sh8000_0000;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom;

        // reset, once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening, no idling
        send_command(CMD_DEL_LAST,  0, 0, 0);               // empty delete last
        send_command(CMD_READ,      0, 0, 0);               // read with nothing held
        send_command(CMD_FIND,      0, 0, 0);               // find with nothing held
        send_command(CMD_APPEND,    5, 0, 0);               // zero count append
        send_command(CMD_APPEND,    32'sh7fff_ffff, 0, 3);
        send_command(CMD_APPEND,    32'sh8000_0000, 0, 2);
        send_command(CMD_INSERT,    9, 6, 1);               // insert past the end
        send_command(CMD_INSERT,    -1, 0, 2);              // insert at head
        send_command(CMD_INSERT,    0, 7, 1);               // insert right at the end
        send_command(CMD_READ,      0, 0, 0);
        send_command(CMD_READ,      0, 7, 0);
        send_command(CMD_READ,      0, 8, 0);               // one past the last word
        send_command(CMD_REPLACE,   32'sh1234_5678, 3, 0);
        send_command(CMD_FIND,      32'sh8000_0000, 0, 0);  // hit
        send_command(CMD_FIND,      32'sh55, 0, 0);         // miss
        send_command(CMD_FIND,      0, 511, 0);             // start way out of range
        send_command(CMD_DEL_RANGE, 0, 2, 0);               // zero count delete
        send_command(CMD_DEL_RANGE, 0, 1, 8);               // runs past the end
        send_command(CMD_DEL_RANGE, 0, 1, 2);
        send_command(CMD_DEL_LAST,  0, 0, 0);
        send_command(CMD_APPEND,    1, 0, CAPACITY);        // would overflow
        send_command(CMD_CLEAR,     0, 0, 0);
        send_command(CMD_APPEND,    -1, 0, CAPACITY);       // fill to capacity
        send_command(CMD_INSERT,    2, 0, 1);               // full
        send_command(CMD_FIND,      -1, 255, 0);            // top index
        send_command(CMD_CLEAR,     0, 0, 0);

        // random: sender idles lightly, receiver stalls heavily
        send_idle_pct  = 28;
        recv_stall_pct = 76;
        repeat (RANDOM_BEATS / 3) send_random_command();

        // swapped profile
        send_idle_pct  = 76;
        recv_stall_pct = 28;
        repeat (RANDOM_BEATS / 3) send_random_command();

        // full throughput
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RANDOM_BEATS - 2 * (RANDOM_BEATS / 3)) send_random_command();
        i_in_valid <= 1'b0;

        // drain: one edge so the last push is visible, then wait out the results
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
